@@ hw/rtl/olte_pkg.sv @@
// Shared types and constants for the object list tile emitter.
// No dependencies; used by the interfaces, the RTL modules and the checker.
package olte_pkg;

  localparam int unsigned ADDR_W     = 13;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CODE_W     = 14;
  localparam int unsigned PAL_W      = 4;
  localparam int unsigned POSX_W     = 10;
  localparam int unsigned POSY_W     = 8;
  localparam int unsigned BANK_W     = 4;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned ROW_W      = 5;

  // sprite geometry, in byte addresses and pixels
  localparam logic [ADDR_W-1:0] SPR_BASE_OFS = 13'd12;
  localparam logic [POSY_W-1:0] SPR_Y_TOP    = 8'd240;
  localparam logic [POSX_W-1:0] COL_STEP     = 10'd16;
  localparam logic [POSX_W-1:0] X_SIGN_OFS   = 10'd256;
  localparam logic [POSX_W-1:0] TILE_W       = 10'd8;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_PROCESS = 1'b1
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

endpackage

@@ hw/rtl/olte_if.sv @@
// Stream interfaces of the object list tile emitter: object/write beats in,
// tile command beats out. Depends on olte_pkg.
interface olte_in_if;
  logic                               valid;
  logic                               ready;
  logic                               operation;
  logic [olte_pkg::ADDR_W-1:0]        address;
  logic [olte_pkg::BYTE_W-1:0]        write_data;
  logic [olte_pkg::BYTE_W-1:0]        obj_y;
  logic [olte_pkg::BYTE_W-1:0]        obj_code;
  logic [olte_pkg::BYTE_W-1:0]        obj_x;
  logic [olte_pkg::BYTE_W-1:0]        obj_attr;
  logic                               first_of_frame;

  modport source (output valid, operation, address, write_data, obj_y, obj_code, obj_x,
                  obj_attr, first_of_frame, input ready);
  modport sink   (input valid, operation, address, write_data, obj_y, obj_code, obj_x,
                  obj_attr, first_of_frame, output ready);
endinterface

interface olte_out_if;
  logic                               valid;
  logic                               ready;
  logic [olte_pkg::CODE_W-1:0]        tile_code;
  logic [olte_pkg::PAL_W-1:0]         palette;
  logic                               flip_x;
  logic                               flip_y;
  logic signed [olte_pkg::POSX_W-1:0] pos_x;
  logic [olte_pkg::POSY_W-1:0]        pos_y;
  logic                               last_tile;

  modport source (output valid, tile_code, palette, flip_x, flip_y, pos_x, pos_y, last_tile,
                  input ready);
  modport sink   (input valid, tile_code, palette, flip_x, flip_y, pos_x, pos_y, last_tile,
                  output ready);
endinterface

@@ hw/rtl/olte_gfx_store.sv @@
// Graphics store: two synchronous byte banks (even and odd addresses) so a
// tile's low and high bytes come out together. Depends on olte_pkg.
module olte_gfx_store #(
  parameter int unsigned STORE_BYTES = 8192
) (
  input  logic                              clk_i,
  input  logic                              wr_en_i,
  input  logic [$clog2(STORE_BYTES)-1:0]    wr_addr_i,
  input  logic [olte_pkg::BYTE_W-1:0]       wr_data_i,
  input  logic                              rd_en_i,
  input  logic [$clog2(STORE_BYTES)-2:0]    rd_idx_i,
  output logic [olte_pkg::BYTE_W-1:0]       rd_lo_o,
  output logic [olte_pkg::BYTE_W-1:0]       rd_hi_o
);

  localparam int unsigned AW    = $clog2(STORE_BYTES);
  localparam int unsigned DEPTH = STORE_BYTES / 2;

  logic [olte_pkg::BYTE_W-1:0] mem_lo [DEPTH];
  logic [olte_pkg::BYTE_W-1:0] mem_hi [DEPTH];
  logic [olte_pkg::BYTE_W-1:0] rd_lo_q;
  logic [olte_pkg::BYTE_W-1:0] rd_hi_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !wr_addr_i[0]) begin
      mem_lo[wr_addr_i[AW-1:1]] <= wr_data_i;
    end
    if (wr_en_i && wr_addr_i[0]) begin
      mem_hi[wr_addr_i[AW-1:1]] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_lo_q <= mem_lo[rd_idx_i];
      rd_hi_q <= mem_hi[rd_idx_i];
    end
  end

  assign rd_lo_o = rd_lo_q;
  assign rd_hi_o = rd_hi_q;

endmodule

@@ hw/rtl/object_list_tile_emitter.sv @@
// Object list tile emitter: write beats fill the graphics store; process beats
// expand an object entry into 4 or 64 tile commands. Depends on olte_pkg,
// olte_in_if/olte_out_if and olte_gfx_store.
// A write beat or an empty entry is done at its accept edge; the first tile of an
//   entry passes the run state, the store read stage and the output register.
// Tiles issue at one per cycle (one banked store read each) while the output is
//   not stalled; the next beat is taken after the entry's last read.
// Reset clears control, the output stage and column x; store contents stay
//   undefined until written, with no clearing pass.
module object_list_tile_emitter #(
  parameter int unsigned STORE_BYTES = 8192
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  olte_in_if.sink    in_i,
  olte_out_if.source out_o
);

  localparam int unsigned AW    = $clog2(STORE_BYTES);
  localparam int unsigned IDX_W = AW - 1;

  olte_pkg::state_e                 state_q, state_d;
  logic [olte_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [IDX_W-1:0]                 base_q, base_d;
  logic                             tall_q, tall_d;
  logic [olte_pkg::POSY_W-1:0]      sy_q, sy_d;
  logic [olte_pkg::POSX_W-1:0]      cx_q, cx_d;
  logic [olte_pkg::BANK_W-1:0]      bank_q, bank_d;

  logic                             s1_valid_q, s1_valid_d;
  logic [olte_pkg::POSX_W-1:0]      s1_pos_x_q;
  logic [olte_pkg::POSY_W-1:0]      s1_pos_y_q;
  logic                             s1_last_q;
  logic [olte_pkg::BANK_W-1:0]      s1_bank_q;

  logic                             out_valid_q, out_valid_d;
  logic [olte_pkg::CODE_W-1:0]      out_code_q;
  logic [olte_pkg::PAL_W-1:0]       out_pal_q;
  logic                             out_fx_q;
  logic                             out_fy_q;
  logic [olte_pkg::POSX_W-1:0]      out_pos_x_q;
  logic [olte_pkg::POSY_W-1:0]      out_pos_y_q;
  logic                             out_last_q;

  logic                             in_acc;
  logic                             is_write;
  logic                             empty;
  logic                             cont;
  logic [olte_pkg::POSX_W-1:0]      cx_start;
  logic [olte_pkg::ADDR_W-1:0]      base_byte;
  logic                             s1_move;
  logic                             issue;
  logic [olte_pkg::ROW_W-1:0]       row;
  logic                             col;
  logic                             last;
  logic [IDX_W-1:0]                 rd_idx;
  logic [olte_pkg::BYTE_W-1:0]      rd_lo;
  logic [olte_pkg::BYTE_W-1:0]      rd_hi;

  assign in_i.ready = (state_q == olte_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_write   = (in_i.operation == olte_pkg::OP_WRITE);
  assign empty      = ({in_i.obj_y, in_i.obj_code, in_i.obj_x, in_i.obj_attr} == '0);
  assign cont       = in_i.obj_code[7] && in_i.obj_code[6];
  assign cx_start   = in_i.first_of_frame ? '0 : cx_q;

  always_comb begin
    if (in_i.obj_code[7]) begin
      base_byte = {in_i.obj_code[5:0], 7'b0};
    end else begin
      base_byte = {1'b0, in_i.obj_code[4:0], 7'b0}
                + {7'b0, in_i.obj_code[6:5], 4'b0}
                + olte_pkg::SPR_BASE_OFS;
    end
  end

  // tile walk: left column top to bottom, then right column
  assign row  = tall_q ? cnt_q[olte_pkg::ROW_W-1:0] : {4'b0, cnt_q[0]};
  assign col  = tall_q ? cnt_q[5] : cnt_q[1];
  assign last = tall_q ? (&cnt_q) : (&cnt_q[1:0]);

  assign rd_idx = base_q + {{(IDX_W-6){1'b0}}, col, 5'b0}
                + {{(IDX_W-olte_pkg::ROW_W){1'b0}}, row};

  assign s1_move = s1_valid_q && (!out_valid_q || out_o.ready);
  assign issue   = (state_q == olte_pkg::ST_RUN) && (!s1_valid_q || s1_move);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    base_d  = base_q;
    tall_d  = tall_q;
    sy_d    = sy_q;
    cx_d    = cx_q;
    bank_d  = bank_q;
    unique case (state_q)
      olte_pkg::ST_IDLE: begin
        if (in_acc && !is_write) begin
          cx_d = cx_start;
          if (!empty) begin
            if (cont) begin
              cx_d = cx_start + olte_pkg::COL_STEP;
            end else begin
              cx_d = {2'b0, in_i.obj_x} - (in_i.obj_attr[6] ? olte_pkg::X_SIGN_OFS : '0);
            end
            base_d  = IDX_W'(base_byte[olte_pkg::ADDR_W-1:1]);
            tall_d  = in_i.obj_code[7];
            sy_d    = (in_i.obj_code[7] ? 8'd0 : olte_pkg::SPR_Y_TOP) - in_i.obj_y;
            bank_d  = in_i.obj_attr[3:0];
            cnt_d   = '0;
            state_d = olte_pkg::ST_RUN;
          end
        end
      end
      olte_pkg::ST_RUN: begin
        if (issue) begin
          cnt_d = cnt_q + 1'b1;
          if (last) begin
            state_d = olte_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = olte_pkg::ST_IDLE;
    endcase
  end

  assign s1_valid_d  = issue ? 1'b1 : (s1_move ? 1'b0 : s1_valid_q);
  assign out_valid_d = (!out_valid_q || out_o.ready) ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= olte_pkg::ST_IDLE;
      cnt_q       <= '0;
      cx_q        <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cx_q        <= cx_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    tall_q <= tall_d;
    sy_q   <= sy_d;
    bank_q <= bank_d;
    if (issue) begin
      s1_pos_x_q <= cx_q + (col ? olte_pkg::TILE_W : '0);
      s1_pos_y_q <= sy_q + {row, 3'b0};
      s1_last_q  <= last;
      s1_bank_q  <= bank_q;
    end
    if (s1_move) begin
      out_code_q  <= {s1_bank_q, rd_hi[1:0], rd_lo};
      out_pal_q   <= rd_hi[5:2];
      out_fx_q    <= rd_hi[6];
      out_fy_q    <= rd_hi[7];
      out_pos_x_q <= s1_pos_x_q;
      out_pos_y_q <= s1_pos_y_q;
      out_last_q  <= s1_last_q;
    end
  end

  olte_gfx_store #(
    .STORE_BYTES(STORE_BYTES)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc && is_write),
    .wr_addr_i (AW'(in_i.address)),
    .wr_data_i (in_i.write_data),
    .rd_en_i   (issue),
    .rd_idx_i  (rd_idx),
    .rd_lo_o   (rd_lo),
    .rd_hi_o   (rd_hi)
  );

  assign out_o.valid     = out_valid_q;
  assign out_o.tile_code = out_code_q;
  assign out_o.palette   = out_pal_q;
  assign out_o.flip_x    = out_fx_q;
  assign out_o.flip_y    = out_fy_q;
  assign out_o.pos_x     = out_pos_x_q;
  assign out_o.pos_y     = out_pos_y_q;
  assign out_o.last_tile = out_last_q;

endmodule

@@ hw/rtl/olte_checker.sv @@
// Port-level checker for object_list_tile_emitter, attached with bind.
// Depends on olte_pkg and the top level's interface ports.
module olte_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               in_operation_i,
  input logic [4*olte_pkg::BYTE_W-1:0]      in_entry_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [olte_pkg::CODE_W-1:0]        out_tile_code_i,
  input logic [olte_pkg::POSX_W-1:0]        out_pos_x_i,
  input logic [olte_pkg::POSY_W-1:0]        out_pos_y_i,
  input logic                               out_last_tile_i
);

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // a write or an empty entry leaves the block idle
  a_no_work_stays_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_operation_i == olte_pkg::OP_WRITE || in_entry_i == '0) |=> in_ready_i)
    else $error("block busy after a beat that makes no tiles");

  // back-to-back tiles of one entry step one tile down or one tile right
  a_tile_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !out_last_tile_i) ##1 out_acc |->
      (out_pos_x_i == $past(out_pos_x_i) + olte_pkg::TILE_W) ||
      (out_pos_x_i == $past(out_pos_x_i) && out_pos_y_i == $past(out_pos_y_i) + 8'd8))
    else $error("tile position does not follow the walk order");

  a_bank_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !out_last_tile_i) ##1 out_acc |->
      out_tile_code_i[olte_pkg::CODE_W-1:10] == $past(out_tile_code_i[olte_pkg::CODE_W-1:10]))
    else $error("code bank changed inside one entry");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pos_x_i))
    else $error("output beat dropped while stalled");

endmodule

bind object_list_tile_emitter olte_checker u_olte_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_operation_i  (in_i.operation),
  .in_entry_i      ({in_i.obj_y, in_i.obj_code, in_i.obj_x, in_i.obj_attr}),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_tile_code_i (out_o.tile_code),
  .out_pos_x_i     (out_o.pos_x),
  .out_pos_y_i     (out_o.pos_y),
  .out_last_tile_i (out_o.last_tile)
);

@@ dv/tb_top.sv @@
// Testbench for object_list_tile_emitter: store writes and object entries go in,
// tile commands come out and are checked against a built-in expansion model.
// Depends on olte_pkg, olte_in_if/olte_out_if and the block's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import olte_pkg::*;

  localparam int unsigned STORE_BYTES = 8192;
  localparam int RAND_BEATS  = 94;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PCT    = 20;
  localparam int MAX_REPORTS = 10;
  localparam logic [7:0] FROM_MODEL = 8'hff;

  typedef struct packed {
    op_e               operation;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] write_data;
    logic [BYTE_W-1:0] obj_y;
    logic [BYTE_W-1:0] obj_code;
    logic [BYTE_W-1:0] obj_x;
    logic [BYTE_W-1:0] obj_attr;
    logic              first_of_frame;
  } obj_beat_t;

  typedef struct packed {
    logic [CODE_W-1:0]        tile_code;
    logic [PAL_W-1:0]         palette;
    logic                     flip_x;
    logic                     flip_y;
    logic signed [POSX_W-1:0] pos_x;
    logic [POSY_W-1:0]        pos_y;
    logic                     last_tile;
  } tile_t;

  // n_tiles/x0/y0: typed count and position of the first tile
  typedef struct packed {
    obj_beat_t                beat;
    logic [7:0]               n_tiles;
    logic signed [POSX_W-1:0] x0;
    logic [POSY_W-1:0]        y0;
  } step_t;

  localparam step_t PLAN [20] = '{
    '{'{OP_PROCESS, 13'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 8'd0, 10'sd0, 8'd0},
    '{'{OP_PROCESS, 13'h1fff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h01, 1'b0}, 8'd4, 10'sd0, 8'd240},
    '{'{OP_PROCESS, 13'h0000, 8'h00, 8'hff, 8'h60, 8'hff, 8'h0f, 1'b0}, 8'd4, 10'sd255, 8'd241},
    '{'{OP_PROCESS, 13'h0000, 8'h00, 8'h00, 8'h20, 8'h80, 8'h40, 1'b0}, 8'd4, -10'sd128, 8'd240},
    '{'{OP_PROCESS, 13'h0000, 8'h00, 8'h00, 8'h80, 8'h10, 8'h00, 1'b0}, 8'd64, 10'sd16, 8'd0},
    '{'{OP_PROCESS, 13'h0000, 8'h00, 8'h00, 8'hc0, 8'h00, 8'h00, 1'b0}, 8'd64, 10'sd32, 8'd0},
    '{'{OP_PROCESS, 13'h0000, 8'h00, 8'hff, 8'hff, 8'h00, 8'hff, 1'b0}, 8'd64, 10'sd48, 8'd1},
    '{'{OP_PROCESS, 13'h0000, 8'h00, 8'h00, 8'hc0, 8'h00, 8'h00, 1'b1}, 8'd64, 10'sd16, 8'd0},
    '{'{OP_PROCESS, 13'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1}, 8'd0, 10'sd0, 8'd0},
    '{'{OP_PROCESS, 13'h0000, 8'h00, 8'h55, 8'hff, 8'h00, 8'h00, 1'b0}, 8'd64, 10'sd16, 8'd171},
    '{'{OP_PROCESS, 13'h0000, 8'h00, 8'h80, 8'hbf, 8'hff, 8'h40, 1'b0}, 8'd64, -10'sd1, 8'd128},
    '{'{OP_PROCESS, 13'h0000, 8'h00, 8'h00, 8'hc0, 8'h00, 8'h00, 1'b0}, 8'd64, 10'sd15, 8'd0},
    '{'{OP_WRITE,   13'h0001, 8'ha5, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1}, 8'd0, 10'sd0, 8'd0},
    '{'{OP_PROCESS, 13'h0000, 8'h00, 8'h08, 8'hc0, 8'h00, 8'h00, 1'b0}, 8'd64, 10'sd31, 8'd248},
    '{'{OP_PROCESS, 13'h0000, 8'h00, 8'h10, 8'h40, 8'h00, 8'h8a, 1'b0}, 8'd4, 10'sd0, 8'd224},
    '{'{OP_WRITE,   13'h1fff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1}, 8'd0, 10'sd0, 8'd0},
    '{'{OP_WRITE,   13'h1f80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 8'd0, 10'sd0, 8'd0},
    '{'{OP_PROCESS, 13'h0000, 8'h00, 8'h00, 8'hbf, 8'h00, 8'h3f, 1'b0}, 8'd64, 10'sd0, 8'd0},
    '{'{OP_PROCESS, 13'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 1'b0}, 8'd4, 10'sd0, 8'd240},
    '{'{OP_PROCESS, 13'h1fff, 8'hff, 8'h37, 8'h00, 8'h00, 8'h00, 1'b0}, FROM_MODEL, 10'sd0, 8'd0}
  };

  logic clk_i;
  logic rst_ni;

  olte_in_if  obj_if ();
  olte_out_if tile_if ();

  object_list_tile_emitter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (obj_if),
    .out_o  (tile_if)
  );

  logic [BYTE_W-1:0] gfx_mem [STORE_BYTES];
  bit                written [STORE_BYTES];
  logic [POSX_W-1:0] col_x;
  tile_t             tile_q [$];
  int                full_blocks [$];
  int                err_cnt;
  int                beats_sent;
  int                cycles;
  int                src_idle_pct;
  int                snk_idle_pct;
  int                hold_req;
  int                hold_ack;
  int                hold_left;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void flag(string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("%0t mismatch: %s", $realtime, msg);
  endfunction

  function automatic string fmt_tile(tile_t t);
    return $sformatf("code=%h pal=%h fx=%b fy=%b x=%0d y=%0d last=%b", t.tile_code,
                     t.palette, t.flip_x, t.flip_y, t.pos_x, t.pos_y, t.last_tile);
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic logic [ADDR_W-1:0] entry_base(logic [7:0] code);
    if (code[7]) return {code[5:0], 7'd0};
    return {1'b0, code[4:0], 7'd0} + {7'd0, code[6:5], 4'd0} + SPR_BASE_OFS;
  endfunction

  // a sprite reads 4 bytes in each tile column, a column entry its whole 128-byte block
  function automatic bit entry_readable(logic [7:0] code);
    logic [ADDR_W-1:0] base;
    base = entry_base(code);
    for (int i = 0; i < 128; i++)
      if ((code[7] || i[5:0] < 4) && !written[base + i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_code();
    logic [7:0] c;
    repeat (24) begin
      c = rnd8();
      if (entry_readable(c)) return c;
    end
    c = {($urandom_range(1) != 0) ? 2'b11 : 2'b10,
         6'(full_blocks[$urandom_range(full_blocks.size() - 1)])};
    return c;
  endfunction

  // Updates the store and column x, queues the tiles of one beat.
  function automatic int expand_beat(obj_beat_t b, output tile_t head);
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] g;
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
    logic [POSY_W-1:0] top;
    int                rows;
    int                n;
    tile_t             t;
    n = 0;
    head = '0;
    if (b.operation == OP_WRITE) begin
      gfx_mem[b.address] = b.write_data;
      written[b.address] = 1'b1;
      return 0;
    end
    if (b.first_of_frame) col_x = '0;
    if ({b.obj_y, b.obj_code, b.obj_x, b.obj_attr} == '0) return 0;
    base = entry_base(b.obj_code);
    rows = b.obj_code[7] ? 32 : 2;
    if (b.obj_code[7:6] == 2'b11) col_x = col_x + COL_STEP;
    else col_x = {2'b00, b.obj_x} - (b.obj_attr[6] ? X_SIGN_OFS : 10'd0);
    top = 8'(0 - 8 * rows) - b.obj_y;
    for (int c = 0; c < 2; c++) begin
      for (int r = 0; r < rows; r++) begin
        g = base + ADDR_W'(c * 64 + r * 2);
        lo = gfx_mem[g];
        hi = gfx_mem[g + 1'b1];
        t.tile_code = {b.obj_attr[3:0], hi[1:0], lo};
        t.palette   = hi[5:2];
        t.flip_x    = hi[6];
        t.flip_y    = hi[7];
        t.pos_x     = col_x + ((c == 1) ? TILE_W : 10'd0);
        t.pos_y     = top + 8'(8 * r);
        t.last_tile = (c == 1 && r == rows - 1);
        if (n == 0) head = t;
        tile_q.push_back(t);
        n++;
      end
    end
    return n;
  endfunction

  function automatic obj_beat_t write_beat(int addr, int data);
    obj_beat_t b;
    b = obj_beat_t'({$urandom, $urandom});
    b.operation  = OP_WRITE;
    b.address    = ADDR_W'(addr);
    b.write_data = 8'(data);
    return b;
  endfunction

  function automatic obj_beat_t entry_beat(logic [7:0] code, logic [7:0] y, logic [7:0] x,
                                           logic [7:0] attr, logic first);
    obj_beat_t b;
    b = obj_beat_t'({$urandom, $urandom});
    b.operation      = OP_PROCESS;
    b.obj_y          = y;
    b.obj_code       = code;
    b.obj_x          = x;
    b.obj_attr       = attr;
    b.first_of_frame = first;
    return b;
  endfunction

  task automatic send_beat(input obj_beat_t b, output int n, output tile_t head);
    while ($urandom_range(99) < src_idle_pct) begin
      obj_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    obj_if.valid          <= 1'b1;
    obj_if.operation      <= b.operation;
    obj_if.address        <= b.address;
    obj_if.write_data     <= b.write_data;
    obj_if.obj_y          <= b.obj_y;
    obj_if.obj_code       <= b.obj_code;
    obj_if.obj_x          <= b.obj_x;
    obj_if.obj_attr       <= b.obj_attr;
    obj_if.first_of_frame <= b.first_of_frame;
    do @(posedge clk_i); while (obj_if.ready !== 1'b1);
    n = expand_beat(b, head);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic push_beat(input obj_beat_t b);
    int    n;
    tile_t head;
    send_beat(b, n, head);
  endtask

  task automatic fill_block(int blk);
    for (int i = 0; i < 128; i++) push_beat(write_beat(blk * 128 + i, $urandom_range(255)));
    full_blocks.push_back(blk);
  endtask

  task automatic run_sprite_seq();
    logic [7:0]        code;
    logic [ADDR_W-1:0] base;
    int                ofs [$];
    int                k;
    code = {1'b0, 7'($urandom)};
    base = entry_base(code);
    ofs = '{0, 1, 2, 3, 64, 65, 66, 67};
    while (ofs.size() != 0) begin
      k = $urandom_range(ofs.size() - 1);
      push_beat(write_beat(base + ofs[k], $urandom_range(255)));
      ofs.delete(k);
    end
    push_beat(entry_beat(code, rnd8(), rnd8(), rnd8(), $urandom_range(9) == 0));
  endtask

  task automatic run_column_chain(int len);
    int blk;
    blk = full_blocks[$urandom_range(full_blocks.size() - 1)];
    push_beat(entry_beat({2'b10, 6'(blk)}, rnd8(), rnd8(), rnd8(), $urandom_range(9) == 0));
    repeat (len) begin
      blk = full_blocks[$urandom_range(full_blocks.size() - 1)];
      push_beat(entry_beat({2'b11, 6'(blk)}, rnd8(), rnd8(), rnd8(), $urandom_range(9) == 0));
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      tile_if.ready <= 1'b0;
    end else begin
      tile_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin : tile_check
    tile_t got;
    tile_t want;
    if (rst_ni && tile_if.valid === 1'b1 && tile_if.ready === 1'b1) begin
      got = '{tile_if.tile_code, tile_if.palette, tile_if.flip_x, tile_if.flip_y,
              tile_if.pos_x, tile_if.pos_y, tile_if.last_tile};
      if (tile_q.size() == 0) begin
        flag({"unexpected tile ", fmt_tile(got)});
      end else begin
        want = tile_q.pop_front();
        if (got.tile_code !== want.tile_code || got.palette !== want.palette ||
            got.flip_x !== want.flip_x || got.flip_y !== want.flip_y ||
            got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
            got.last_tile !== want.last_tile)
          flag({"expected ", fmt_tile(want), " got ", fmt_tile(got)});
      end
    end
  end

  initial begin
    int    n;
    tile_t head;
    int    start;
    int    kind;
    bit    pressed;
    bit    quiet;
    rst_ni                = 1'b0;
    obj_if.valid          = 1'b0;
    obj_if.operation      = OP_WRITE;
    obj_if.address        = '0;
    obj_if.write_data     = '0;
    obj_if.obj_y          = '0;
    obj_if.obj_code       = '0;
    obj_if.obj_x          = '0;
    obj_if.obj_attr       = '0;
    obj_if.first_of_frame = 1'b0;
    tile_if.ready         = 1'b0;
    col_x                 = '0;
    pressed               = 1'b0;
    src_idle_pct          = IDLE_PCT;
    snk_idle_pct          = IDLE_PCT;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // lowest and highest blocks, so column entries and every address bit are covered
    fill_block(0);
    fill_block(63);

    for (int i = 0; i < $size(PLAN); i++) begin
      send_beat(PLAN[i].beat, n, head);
      if (PLAN[i].n_tiles != FROM_MODEL &&
          (n != PLAN[i].n_tiles ||
           (n != 0 && (head.pos_x != PLAN[i].x0 || head.pos_y != PLAN[i].y0))))
        flag($sformatf("step %0d: table %0d tiles at (%0d,%0d), model %0d at (%0d,%0d)", i,
                       PLAN[i].n_tiles, PLAN[i].x0, PLAN[i].y0, n, head.pos_x, head.pos_y));
    end

    start = beats_sent;
    while (beats_sent - start < RAND_BEATS) begin
      quiet = (beats_sent - start >= 20) && (beats_sent - start < 50);
      src_idle_pct = quiet ? 0 : IDLE_PCT;
      snk_idle_pct = quiet ? 0 : IDLE_PCT;
      if (!pressed && beats_sent - start >= 60) begin
        pressed = 1'b1;
        src_idle_pct = 0;
        hold_req++;
        run_column_chain(5);
        src_idle_pct = IDLE_PCT;
      end
      kind = $urandom_range(99);
      if (kind < 30) begin
        run_sprite_seq();
      end else if (kind < 55) begin
        push_beat(entry_beat(pick_code(), rnd8(), rnd8(), rnd8(), $urandom_range(9) == 0));
      end else if (kind < 72) begin
        run_column_chain(($urandom_range(7) == 0) ? $urandom_range(16, 24)
                                                  : $urandom_range(1, 5));
      end else if (kind < 80) begin
        push_beat(entry_beat(8'h00, 8'h00, 8'h00, 8'h00, $urandom_range(1)));
      end else begin
        repeat ($urandom_range(1, 3))
          push_beat(write_beat($urandom_range(STORE_BYTES - 1), $urandom_range(255)));
      end
    end

    obj_if.valid <= 1'b0;
    while (tile_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (err_cnt == 0 && tile_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/olte_pkg.sv
hw/rtl/olte_if.sv
hw/rtl/olte_gfx_store.sv
hw/rtl/object_list_tile_emitter.sv
hw/rtl/olte_checker.sv
dv/tb_top.sv
